/* sv/delimited_packet_receiver_core_defines.svh */
// Assertion macros shared by the checker of the packet receiver.
`ifndef DELIMITED_PACKET_RECEIVER_CORE_DEFINES_SVH
`define DELIMITED_PACKET_RECEIVER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define DPR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define DPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/dpr_pkg.sv */
// Types and constants shared by the packet receiver modules.
`default_nettype none
package dpr_pkg;

	localparam int RPOS_W = 9;
	localparam int POS_W = 6;

	localparam logic [7:0] START_RST = 8'h3E;
	localparam logic [7:0] END_RST = 8'h3C;
	localparam logic [7:0] CKS_INV = 8'hFF;

	localparam logic REG_START = 1'b0;
	localparam logic REG_END = 1'b1;

	localparam logic [1:0] STAT_GOOD = 2'd0;
	localparam logic [1:0] STAT_CKS = 2'd1;
	localparam logic [1:0] STAT_COUNT = 2'd2;
	localparam logic [1:0] STAT_OVF = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TYPE,
		ST_LEN,
		ST_CKS,
		ST_SUM,
		ST_STAT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic clear;
		logic push;
	} store_cmd_t;

endpackage
`default_nettype wire

/* sv/dpr_store.sv */
// Frame store with fill count, overflow flag and a registered, gated read port.
`default_nettype none
module dpr_store #(
	parameter int DEPTH = 64
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire dpr_pkg::store_cmd_t       cmd,
	input  wire logic [7:0]                wr_data,
	input  wire logic [dpr_pkg::RPOS_W-1:0] rd_pos,
	output logic [7:0]                     rd_data,
	output logic [$clog2(DEPTH+1)-1:0]     fill,
	output logic                           ovf
);

	localparam int AW = $clog2(DEPTH);
	localparam int WPW = $clog2(DEPTH + 1);
	localparam logic [WPW-1:0] FULL = WPW'(DEPTH);

	logic [7:0]     mem_q [DEPTH];
	logic [7:0]     rdata_q;
	logic           rvalid_q;
	logic [WPW-1:0] wp_q;
	logic           ovf_q;
	logic           rd_ok;
	logic [AW-1:0]  rd_idx;
	logic           full;

	assign full = (wp_q == FULL);
	assign rd_ok = (rd_pos < dpr_pkg::RPOS_W'(wp_q));
	assign rd_idx = rd_ok ? rd_pos[AW-1:0] : '0;

	always_ff @(posedge clk) begin
		if (cmd.push && !full) begin
			mem_q[wp_q[AW-1:0]] <= wr_data;
		end
		rdata_q <= mem_q[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			ovf_q <= 1'b0;
			rvalid_q <= 1'b0;
		end else begin
			rvalid_q <= rd_ok;
			if (cmd.clear) begin
				wp_q <= '0;
				ovf_q <= 1'b0;
			end else if (cmd.push) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					wp_q <= wp_q + 1'b1;
				end
			end
		end
	end

	assign rd_data = rvalid_q ? rdata_q : 8'd0;
	assign fill = wp_q;
	assign ovf = ovf_q;

endmodule
`default_nettype wire

/* sv/delimited_packet_receiver_core.sv */
// Top level of the delimited packet receiver: framing, checksum sequencer and readout.
//
// Channel   Dir  Signals                        Contents
// s_*       in   s_tvalid s_tready s_tdata      received byte
// m_*       out  m_tvalid m_tready m_tdata ...  one result beat per payload byte
// apb       in   psel penable pwrite paddr ...  start and end byte registers
//
// Ordinary and start bytes do not stall. An end byte starts reads of type, length and
// checksum, a sum of up to BUFFER_DEPTH - 2 payload bytes, then up to BUFFER_DEPTH - 3
// result beats (one without data if empty); the store's single read port sets this pace.
// Reset is asynchronous; the store contents need no clearing pass.
// A low m_tready holds the readout; s_tready stays low from the end byte to the last beat.
`default_nettype none
module delimited_packet_receiver_core #(
	parameter int BUFFER_DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [7:0] packet_type, [15:8] packet_length, [23:16] data_byte, [29:24] data_position,
	// [37:30] received_checksum, [39:38] status
	output logic [39:0]      m_tdata,
	output logic [0:0]       m_tuser,   // [0] has_data
	output logic             m_tlast,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int CW = $clog2(BUFFER_DEPTH);
	localparam int WPW = $clog2(BUFFER_DEPTH + 1);
	localparam int RW = dpr_pkg::RPOS_W;
	localparam logic [7:0] LIM_SUM8 = 8'(BUFFER_DEPTH - 2);
	localparam logic [7:0] LIM_OUT8 = 8'(BUFFER_DEPTH - 3);

	dpr_pkg::state_t     state_q, state_d;
	dpr_pkg::store_cmd_t cmd;

	logic [7:0]     start_q, end_q;
	logic [7:0]     type_q, len_q, cks_q, sum_q;
	logic [CW-1:0]  lim_q, n_q, cnt_q;
	logic [1:0]     stat_q;
	logic [RW-1:0]  rd_pos;
	logic [7:0]     rd_data;
	logic [WPW-1:0] fill;
	logic           ovf;
	logic           in_acc, is_start, is_end, load, last_w, has_w;
	logic [1:0]     stat_w;

	logic           m_valid_q;
	logic [39:0]    m_data_q;
	logic           m_user_q, m_last_q;

	assign pready = 1'b1;
	assign prdata = {24'd0, (paddr[2] == dpr_pkg::REG_END) ? end_q : start_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= dpr_pkg::START_RST;
			end_q <= dpr_pkg::END_RST;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == dpr_pkg::REG_END) begin
				end_q <= pwdata[7:0];
			end else begin
				start_q <= pwdata[7:0];
			end
		end
	end

	assign in_acc = s_tvalid && s_tready;
	assign is_start = (s_tdata == start_q);
	assign is_end = !is_start && (s_tdata == end_q);
	assign cmd.clear = in_acc && is_start;
	assign cmd.push = in_acc && !is_start && !is_end;

	dpr_store #(
		.DEPTH(BUFFER_DEPTH)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.wr_data(s_tdata),
		.rd_pos(rd_pos),
		.rd_data(rd_data),
		.fill(fill),
		.ovf(ovf)
	);

	assign load = !m_valid_q || m_tready;
	assign has_w = (n_q != '0);
	assign last_w = !has_w || ((CW + 1)'(cnt_q) + 1'b1 == (CW + 1)'(n_q));

	always_comb begin
		if (ovf) begin
			stat_w = dpr_pkg::STAT_OVF;
		end else if (RW'(fill) != RW'(len_q) + RW'(3)) begin
			stat_w = dpr_pkg::STAT_COUNT;
		end else if ((sum_q ^ dpr_pkg::CKS_INV) != cks_q) begin
			stat_w = dpr_pkg::STAT_CKS;
		end else begin
			stat_w = dpr_pkg::STAT_GOOD;
		end
	end

	always_comb begin
		case (state_q)
			dpr_pkg::ST_IDLE: rd_pos = RW'(0);
			dpr_pkg::ST_TYPE: rd_pos = RW'(1);
			dpr_pkg::ST_LEN:  rd_pos = RW'(rd_data) + RW'(2);
			dpr_pkg::ST_CKS:  rd_pos = RW'(2);
			dpr_pkg::ST_SUM:  rd_pos = RW'(cnt_q) + RW'(3);
			dpr_pkg::ST_STAT: rd_pos = RW'(2);
			dpr_pkg::ST_EMIT: rd_pos = RW'(cnt_q) + (load ? RW'(3) : RW'(2));
			default:          rd_pos = RW'(0);
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			dpr_pkg::ST_IDLE: begin
				if (in_acc && is_end) begin
					state_d = dpr_pkg::ST_TYPE;
				end
			end
			dpr_pkg::ST_TYPE: state_d = dpr_pkg::ST_LEN;
			dpr_pkg::ST_LEN:  state_d = dpr_pkg::ST_CKS;
			dpr_pkg::ST_CKS: begin
				state_d = (lim_q == '0) ? dpr_pkg::ST_STAT : dpr_pkg::ST_SUM;
			end
			dpr_pkg::ST_SUM: begin
				if ((CW + 1)'(cnt_q) + 1'b1 == (CW + 1)'(lim_q)) begin
					state_d = dpr_pkg::ST_STAT;
				end
			end
			dpr_pkg::ST_STAT: state_d = dpr_pkg::ST_EMIT;
			dpr_pkg::ST_EMIT: begin
				if (load && last_w) begin
					state_d = dpr_pkg::ST_IDLE;
				end
			end
			default: state_d = dpr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		case (state_q)
			dpr_pkg::ST_IDLE: s_tready = 1'b1;
			default:          s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dpr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			dpr_pkg::ST_TYPE: type_q <= rd_data;
			dpr_pkg::ST_LEN: begin
				len_q <= rd_data;
				lim_q <= (rd_data < LIM_SUM8) ? rd_data[CW-1:0] : LIM_SUM8[CW-1:0];
				n_q <= (rd_data < LIM_OUT8) ? rd_data[CW-1:0] : LIM_OUT8[CW-1:0];
			end
			dpr_pkg::ST_CKS: begin
				cks_q <= rd_data;
				sum_q <= type_q + len_q;
				cnt_q <= '0;
			end
			dpr_pkg::ST_SUM: begin
				sum_q <= sum_q + rd_data;
				cnt_q <= cnt_q + 1'b1;
			end
			dpr_pkg::ST_STAT: begin
				stat_q <= stat_w;
				cnt_q <= '0;
			end
			dpr_pkg::ST_EMIT: begin
				if (load) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == dpr_pkg::ST_EMIT && load) begin
			m_data_q <= {stat_q, cks_q,
				has_w ? dpr_pkg::POS_W'(cnt_q) : dpr_pkg::POS_W'(0),
				has_w ? rd_data : 8'd0, len_q, type_q};
			m_user_q <= has_w;
			m_last_q <= last_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == dpr_pkg::ST_EMIT && load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;
	assign m_tuser = m_user_q;
	assign m_tlast = m_last_q;

endmodule
`default_nettype wire

/* sv/dpr_checker.sv */
// Port-level checker for the packet receiver and its bind to the top level.
`default_nettype none
`include "delimited_packet_receiver_core_defines.svh"
module dpr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata,
	input wire logic [0:0]  m_tuser,
	input wire logic        m_tlast
);

	`DPR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result beat changed")
	`DPR_ASSERT_NOW(a_nodata_last, m_tvalid && !m_tuser[0], m_tlast, "beat without data is not the last beat")
	`DPR_ASSERT_NOW(a_nodata_zero, m_tvalid && !m_tuser[0], m_tdata[29:16] == 14'd0, "beat without data carries a data byte or position")
	`DPR_ASSERT_NOW(a_busy_in_frame, m_tvalid && m_tready && !m_tlast, !s_tready, "input taken during frame readout")

endmodule

bind delimited_packet_receiver_core dpr_checker u_dpr_checker (.*);
`default_nettype wire
